// ===== rtl/tcw_pkg.sv =====
// Shared types and constants for the text console character writer.
// Depends on nothing; tcw_seq, the top level and the checker import it.
package tcw_pkg;

  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int TAB_STOP = 4;
  localparam int CELLS    = ROWS * COLUMNS;

  localparam int ADDR_W  = $clog2(CELLS);
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int ROW_W   = (ROWS > 2) ? $clog2(ROWS) : 1;
  localparam int PH_W    = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
  localparam int REM_W   = $clog2(TAB_STOP + 1);

  localparam int CMD_W   = 2;
  localparam int CODE_W  = 8;
  localparam int COLOR_W = 8;
  localparam int POS_W   = 11;
  localparam int IDX_W   = 11;

  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  localparam logic [CODE_W-1:0] CH_NUL   = 8'd0;
  localparam logic [CODE_W-1:0] CH_BS    = 8'd8;
  localparam logic [CODE_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CODE_W-1:0] CH_NL    = 8'd10;
  localparam logic [CODE_W-1:0] CH_CR    = 8'd13;
  localparam logic [CODE_W-1:0] CH_SPACE = 8'd32;

  localparam logic [COLOR_W-1:0] FILL_RESET = 8'd7;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic               we_char;
    logic               we_color;
    logic [CODE_W-1:0]  wchar;
    logic [COLOR_W-1:0] wcolor;
  } mem_req_t;

  typedef struct packed {
    logic [POS_W-1:0]   cursor_pos;
    logic [CODE_W-1:0]  read_char;
    logic [COLOR_W-1:0] read_color;
  } result_t;

endpackage

// ===== rtl/tcw_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module tcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/tcw_seq.sv =====
// Command sequencer: cursor, ring row base, grid sweeps and memory requests.
// Depends on tcw_pkg; drives the character and color RAMs through mem_req_t.
module tcw_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [tcw_pkg::CMD_W-1:0]    in_cmd,
  input  logic [tcw_pkg::CODE_W-1:0]   in_char_code,
  input  logic [tcw_pkg::IDX_W-1:0]    in_cell_index,
  input  logic [tcw_pkg::COLOR_W-1:0]  fill_color,
  output logic                         res_valid,
  input  logic                         res_ready,
  output tcw_pkg::result_t             res,
  output tcw_pkg::mem_req_t            mem_req,
  input  logic [tcw_pkg::CODE_W-1:0]   rd_char,
  input  logic [tcw_pkg::COLOR_W-1:0]  rd_color
);
  import tcw_pkg::*;

  localparam logic [2:0] ST_SWEEP  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_PUT    = 3'd2;
  localparam logic [2:0] ST_SCROLL = 3'd3;
  localparam logic [2:0] ST_RDCAP  = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [ADDR_W-1:0]  row_start_r, row_start_nxt;
  logic [PH_W-1:0]    ph_r, ph_nxt;
  logic [ADDR_W-1:0]  base_r, base_nxt;
  logic [ADDR_W-1:0]  cnt_r, cnt_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [CODE_W-1:0]  code_r, code_nxt;
  logic [COLOR_W-1:0] sweep_color_r, sweep_color_nxt;
  logic               sweep_rsp_r, sweep_rsp_nxt;
  logic [CODE_W-1:0]  rc_r, rc_nxt;
  logic [COLOR_W-1:0] rcol_r, rcol_nxt;

  logic [ADDR_W:0]    cur_sum, rd_sum, base_sum;
  logic [ADDR_W-1:0]  cur_phys, rd_phys, base_adv;
  logic               rd_in_range;
  logic [PH_W-1:0]    ph_inc, ph_dec;
  logic               last_col, last_row, accept;

  // Logical row 0 sits at physical offset base_r; fold sums back into the grid.
  assign cur_sum  = {1'b0, row_start_r} + (ADDR_W+1)'(col_r) + {1'b0, base_r};
  assign cur_phys = (cur_sum >= (ADDR_W+1)'(CELLS)) ?
                    ADDR_W'(cur_sum - (ADDR_W+1)'(CELLS)) : ADDR_W'(cur_sum);
  assign rd_sum   = (ADDR_W+1)'(in_cell_index) + {1'b0, base_r};
  assign rd_phys  = (rd_sum >= (ADDR_W+1)'(CELLS)) ?
                    ADDR_W'(rd_sum - (ADDR_W+1)'(CELLS)) : ADDR_W'(rd_sum);
  assign rd_in_range = (32'(in_cell_index) < 32'(CELLS));
  assign base_sum = {1'b0, base_r} + (ADDR_W+1)'(COLUMNS);
  assign base_adv = (base_sum >= (ADDR_W+1)'(CELLS)) ? '0 : ADDR_W'(base_sum);

  assign ph_inc   = (ph_r == PH_W'(TAB_STOP - 1)) ? '0 : ph_r + PH_W'(1);
  assign ph_dec   = (ph_r == '0) ? PH_W'(TAB_STOP - 1) : ph_r - PH_W'(1);
  assign last_col = (col_r == COL_W'(COLUMNS - 1));
  assign last_row = (row_r == ROW_W'(ROWS - 1));

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign res_valid = (state_r == ST_DONE);

  assign res.cursor_pos = POS_W'(row_start_r + ADDR_W'(col_r));
  assign res.read_char  = rc_r;
  assign res.read_color = rcol_r;

  always_comb begin
    state_nxt       = state_r;
    col_nxt         = col_r;
    row_nxt         = row_r;
    row_start_nxt   = row_start_r;
    ph_nxt          = ph_r;
    base_nxt        = base_r;
    cnt_nxt         = cnt_r;
    rem_nxt         = rem_r;
    code_nxt        = code_r;
    sweep_color_nxt = sweep_color_r;
    sweep_rsp_nxt   = sweep_rsp_r;
    rc_nxt          = rc_r;
    rcol_nxt        = rcol_r;

    mem_req.addr     = (in_cmd == CMD_READ) ? rd_phys : cur_phys - ADDR_W'(1);
    mem_req.we_char  = 1'b0;
    mem_req.we_color = 1'b0;
    mem_req.wchar    = CH_SPACE;
    mem_req.wcolor   = fill_color;

    unique case (state_r)
      ST_SWEEP: begin
        mem_req.addr     = cnt_r;
        mem_req.we_char  = 1'b1;
        mem_req.we_color = 1'b1;
        mem_req.wchar    = CH_NUL;
        mem_req.wcolor   = sweep_color_r;
        cnt_nxt          = cnt_r + ADDR_W'(1);
        if (cnt_r == ADDR_W'(CELLS - 1)) begin
          state_nxt = sweep_rsp_r ? ST_DONE : ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          rc_nxt   = '0;
          rcol_nxt = '0;
          state_nxt = ST_DONE;
          unique case (in_cmd)
            CMD_PUT: begin
              priority case (in_char_code)
                CH_NL: begin
                  col_nxt = '0;
                  ph_nxt  = '0;
                  rem_nxt = '0;
                  if (last_row) begin
                    cnt_nxt   = '0;
                    state_nxt = ST_SCROLL;
                  end else begin
                    row_nxt       = row_r + ROW_W'(1);
                    row_start_nxt = row_start_r + ADDR_W'(COLUMNS);
                  end
                end
                CH_CR: begin
                  col_nxt = '0;
                  ph_nxt  = '0;
                end
                CH_TAB: begin
                  rem_nxt   = REM_W'(TAB_STOP) - REM_W'(ph_r);
                  code_nxt  = CH_SPACE;
                  state_nxt = ST_PUT;
                end
                CH_BS: begin
                  // Blank the cell left of the cursor; it never crosses a row.
                  if (col_r != '0) begin
                    mem_req.we_char = 1'b1;
                    col_nxt = col_r - COL_W'(1);
                    ph_nxt  = ph_dec;
                  end
                end
                default: begin
                  rem_nxt   = REM_W'(1);
                  code_nxt  = in_char_code;
                  state_nxt = ST_PUT;
                end
              endcase
            end
            CMD_READ: begin
              if (rd_in_range) begin
                state_nxt = ST_RDCAP;
              end
            end
            CMD_CLEAR: begin
              cnt_nxt         = '0;
              sweep_color_nxt = fill_color;
              sweep_rsp_nxt   = 1'b1;
              base_nxt        = '0;
              col_nxt         = '0;
              row_nxt         = '0;
              row_start_nxt   = '0;
              ph_nxt          = '0;
              state_nxt       = ST_SWEEP;
            end
            default: ;
          endcase
        end
      end

      ST_PUT: begin
        mem_req.addr    = cur_phys;
        mem_req.we_char = 1'b1;
        mem_req.wchar   = code_r;
        rem_nxt         = rem_r - REM_W'(1);
        if (last_col) begin
          col_nxt = '0;
          ph_nxt  = '0;
          if (last_row) begin
            cnt_nxt   = '0;
            state_nxt = ST_SCROLL;
          end else begin
            row_nxt       = row_r + ROW_W'(1);
            row_start_nxt = row_start_r + ADDR_W'(COLUMNS);
            state_nxt     = (rem_r == REM_W'(1)) ? ST_DONE : ST_PUT;
          end
        end else begin
          col_nxt   = col_r + COL_W'(1);
          ph_nxt    = ph_inc;
          state_nxt = (rem_r == REM_W'(1)) ? ST_DONE : ST_PUT;
        end
      end

      // Blank the oldest physical row, then make it the new last row.
      ST_SCROLL: begin
        mem_req.addr     = base_r + cnt_r;
        mem_req.we_char  = 1'b1;
        mem_req.we_color = 1'b1;
        mem_req.wchar    = CH_NUL;
        mem_req.wcolor   = fill_color;
        cnt_nxt          = cnt_r + ADDR_W'(1);
        if (cnt_r == ADDR_W'(COLUMNS - 1)) begin
          base_nxt  = base_adv;
          state_nxt = (rem_r != '0) ? ST_PUT : ST_DONE;
        end
      end

      ST_RDCAP: begin
        rc_nxt    = rd_char;
        rcol_nxt  = rd_color;
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_SWEEP;
      col_r         <= '0;
      row_r         <= '0;
      row_start_r   <= '0;
      ph_r          <= '0;
      base_r        <= '0;
      cnt_r         <= '0;
      rem_r         <= '0;
      sweep_color_r <= FILL_RESET;
      sweep_rsp_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      col_r         <= col_nxt;
      row_r         <= row_nxt;
      row_start_r   <= row_start_nxt;
      ph_r          <= ph_nxt;
      base_r        <= base_nxt;
      cnt_r         <= cnt_nxt;
      rem_r         <= rem_nxt;
      sweep_color_r <= sweep_color_nxt;
      sweep_rsp_r   <= sweep_rsp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
    rc_r   <= rc_nxt;
    rcol_r <= rcol_nxt;
  end

endmodule

// ===== rtl/text_console_char_writer.sv =====
// Text console top level: fill color register, result register, two cell RAMs.
// Depends on tcw_pkg, tcw_ram and tcw_seq.
//
// A text console over a ROWS x COLUMNS grid held in two single-port RAMs
// (character and color bytes), addressed through a ring row base so that a
// scroll rewrites only the one row that comes in at the bottom. After reset
// the block runs a clearing pass over all CELLS cells (2000 at 80 x 25) with
// in_ready low; cfg writes are taken during it. Items are handled one at a
// time: a plain character is accepted, written to the character RAM and its
// result loaded; a newline, return or backspace goes from acceptance straight
// to the result load; a read captures the RAM read data before the result
// load, and a read past the grid skips the capture; a tab writes one space
// per column up to the next tab stop; each scroll adds the blanking of one
// row; and a clear sweeps the full grid. A result waiting in the output
// register does not hold up the next item until that item is done.
module text_console_char_writer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [tcw_pkg::COLOR_W-1:0]  cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [tcw_pkg::CMD_W-1:0]    in_cmd,
  input  logic [tcw_pkg::CODE_W-1:0]   in_char_code,
  input  logic [tcw_pkg::IDX_W-1:0]    in_cell_index,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tcw_pkg::POS_W-1:0]    out_cursor_pos,
  output logic [tcw_pkg::CODE_W-1:0]   out_read_char,
  output logic [tcw_pkg::COLOR_W-1:0]  out_read_color
);
  import tcw_pkg::*;

  logic [COLOR_W-1:0] fill_color_r;
  logic               out_valid_r, out_valid_nxt;
  result_t            out_r;
  result_t            res;
  logic               res_valid, res_ready;
  mem_req_t           mem_req;
  logic [CODE_W-1:0]  rd_char;
  logic [COLOR_W-1:0] rd_color;

  assign res_ready = !out_valid_r || out_ready;

  tcw_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_char_code (in_char_code),
    .in_cell_index(in_cell_index),
    .fill_color   (fill_color_r),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .mem_req      (mem_req),
    .rd_char      (rd_char),
    .rd_color     (rd_color)
  );

  tcw_ram #(.WIDTH(CODE_W), .DEPTH(CELLS)) u_char_ram (
    .clk  (clk),
    .we   (mem_req.we_char),
    .addr (mem_req.addr),
    .wdata(mem_req.wchar),
    .rdata(rd_char)
  );

  tcw_ram #(.WIDTH(COLOR_W), .DEPTH(CELLS)) u_color_ram (
    .clk  (clk),
    .we   (mem_req.we_color),
    .addr (mem_req.addr),
    .wdata(mem_req.wcolor),
    .rdata(rd_color)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_color_r <= FILL_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        fill_color_r <= cfg_wr_data;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load a finished result only when the slot is free or draining.
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cursor_pos = out_r.cursor_pos;
  assign out_read_char  = out_r.read_char;
  assign out_read_color = out_r.read_color;

endmodule

// ===== rtl/tcw_checker.sv =====
// Port-level checks for the text console, attached to the top level by bind.
// Depends on tcw_pkg and the text_console_char_writer port list.
module tcw_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [tcw_pkg::POS_W-1:0]    out_cursor_pos,
  input logic [tcw_pkg::CODE_W-1:0]   out_read_char,
  input logic [tcw_pkg::COLOR_W-1:0]  out_read_color
);
  import tcw_pkg::*;

  // Reset always starts the grid clearing pass, which blocks input.
  a_reset_sweep: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input ready right after reset");

  // One transaction at a time: ready drops after every accepted item.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready held after an accepted transaction");

  // Cursor always reported inside the grid.
  a_cursor_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_cursor_pos) < CELLS) || (CELLS > 2048))
    else $error("cursor position outside the grid");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cursor_pos)
      && $stable(out_read_char) && $stable(out_read_color))
    else $error("stalled result changed");

endmodule

bind text_console_char_writer tcw_checker u_tcw_checker (.*);
